// ===== sv/fpsl_pkg.sv =====
package fpsl_pkg;

   localparam int COUNT_BITS = 20;
   localparam int CFG_BITS   = 20;
   localparam int CSR_IDX_BITS = 2;
   localparam int BEAT_BITS  = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_BITS-1:0] PULSE_TICKS_RESET  = CFG_BITS'(1000);
   localparam logic [CFG_BITS-1:0] INIT_TIMEOUT_RESET = CFG_BITS'(100000);
   localparam logic [CFG_BITS-1:0] DONE_TIMEOUT_RESET = CFG_BITS'(1000000);

   localparam logic [CSR_IDX_BITS-1:0] CSR_PULSE_TICKS  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INIT_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DONE_TIMEOUT = 2'd2;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_DATA  = 2'd1;
   localparam logic [1:0] MODE_END   = 2'd2;
   localparam logic [1:0] MODE_TICK  = 2'd3;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_BUSY     = 3'd1;
   localparam logic [2:0] ST_OK       = 3'd2;
   localparam logic [2:0] ST_ABSENT   = 3'd3;
   localparam logic [2:0] ST_INIT_TO  = 3'd4;
   localparam logic [2:0] ST_PROG_ERR = 3'd5;
   localparam logic [2:0] ST_DONE_TO  = 3'd6;

   localparam logic [BEAT_BITS-1:0] LAST_BEAT = '1;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_PULSE    = 6'b000010,
      PH_INIT     = 6'b000100,
      PH_LOAD     = 6'b001000,
      PH_DWAIT    = 6'b010000,
      PH_FINISHED = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       burst;
      logic       nconfig;
      logic       data0;
      logic [2:0] status;
      logic [7:0] data_byte;
   } cmd_type;

endpackage

// ===== sv/fpsl_front.sv =====
module fpsl_front
   import fpsl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_mode,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_nstatus_pin,
   input  logic                    req_conf_done_pin,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata,
   input  logic                    q_full,
   output logic                    q_push,
   output cmd_type                 q_cmd
);

   logic [CFG_BITS-1:0]   pulse_ticks_ff, init_timeout_ff, done_timeout_ff;
   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] wait_ff, wait_in, wait_inc;
   logic [2:0]            code_ff, code_in;
   logic                  nconfig_ff, nconfig_in;
   logic                  data0_ff, data0_in;
   logic [CFG_BITS-1:0]   limit;
   logic                  hit;
   logic                  accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff  <= PULSE_TICKS_RESET;
         init_timeout_ff <= INIT_TIMEOUT_RESET;
         done_timeout_ff <= DONE_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PULSE_TICKS:  pulse_ticks_ff  <= csr_wdata;
            CSR_INIT_TIMEOUT: init_timeout_ff <= csr_wdata;
            CSR_DONE_TIMEOUT: done_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_PULSE: limit = pulse_ticks_ff;
         PH_INIT:  limit = init_timeout_ff;
         default:  limit = done_timeout_ff;
      endcase
      wait_inc = (wait_ff == '1) ? wait_ff : wait_ff + COUNT_BITS'(1);
      hit      = wait_inc >= limit;
   end

   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      code_in    = code_ff;
      nconfig_in = nconfig_ff;
      data0_in   = data0_ff;
      if (accept) begin
         unique case (req_mode)
            MODE_START: begin
               nconfig_in = 1'b0;
               data0_in   = 1'b0;
               phase_in   = PH_PULSE;
               wait_in    = '0;
               code_in    = ST_BUSY;
            end
            MODE_DATA: begin
               if (phase_ff == PH_LOAD) data0_in = req_data_byte[7];
            end
            MODE_END: begin
               if (phase_ff == PH_LOAD) begin
                  wait_in = '0;
                  if (!req_nstatus_pin) begin
                     code_in  = ST_PROG_ERR;
                     phase_in = PH_FINISHED;
                  end else begin
                     phase_in = PH_DWAIT;
                  end
               end
            end
            default: begin
               priority if (phase_ff == PH_PULSE) begin
                  wait_in = wait_inc;
                  if (hit) begin
                     wait_in = '0;
                     if (req_nstatus_pin) begin
                        code_in  = ST_ABSENT;
                        phase_in = PH_FINISHED;
                     end else begin
                        nconfig_in = 1'b1;
                        phase_in   = PH_INIT;
                     end
                  end
               end else if (phase_ff == PH_INIT) begin
                  if (req_nstatus_pin) begin
                     phase_in = PH_LOAD;
                     wait_in  = '0;
                  end else begin
                     wait_in = wait_inc;
                     if (hit) begin
                        code_in  = ST_INIT_TO;
                        phase_in = PH_FINISHED;
                        wait_in  = '0;
                     end
                  end
               end else if (phase_ff == PH_DWAIT) begin
                  if (req_conf_done_pin) begin
                     code_in  = ST_OK;
                     phase_in = PH_FINISHED;
                     wait_in  = '0;
                  end else begin
                     wait_in = wait_inc;
                     if (hit) begin
                        code_in  = ST_DONE_TO;
                        phase_in = PH_FINISHED;
                        wait_in  = '0;
                     end
                  end
               end else begin
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         wait_ff    <= '0;
         code_ff    <= ST_IDLE;
         nconfig_ff <= 1'b1;
         data0_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         wait_ff    <= wait_in;
         code_ff    <= code_in;
         nconfig_ff <= nconfig_in;
         data0_ff   <= data0_in;
      end
   end

   assign q_push            = accept;
   assign q_cmd.burst       = (req_mode == MODE_DATA) && (phase_ff == PH_LOAD);
   assign q_cmd.nconfig     = nconfig_in;
   assign q_cmd.data0       = data0_in;
   assign q_cmd.status      = code_in;
   assign q_cmd.data_byte   = req_data_byte;

endmodule

// ===== sv/fpsl_queue.sv =====
module fpsl_queue
   import fpsl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head_cmd
);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]   count_ff;

   assign full     = count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         if (push && !pop)      count_ff <= count_ff + (QPTR_BITS+1)'(1);
         else if (pop && !push) count_ff <= count_ff - (QPTR_BITS+1)'(1);
      end
   end

endmodule

// ===== sv/fpsl_back.sv =====
module fpsl_back
   import fpsl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_nconfig_out,
   output logic       rsp_dclk_out,
   output logic       rsp_data0_out,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   cmd_type              cmd_ff;
   logic                 active_ff;
   logic [BEAT_BITS-1:0] beat_ff;
   logic                 valid_ff;
   logic                 nconfig_ff, dclk_ff, data0_ff, last_ff;
   logic [2:0]           status_ff;
   logic                 out_free, step, final_beat;

   assign out_free   = !valid_ff || rsp_ready;
   assign step       = active_ff && out_free;
   assign final_beat = !cmd_ff.burst || (beat_ff == LAST_BEAT);
   assign q_pop      = !q_empty && (!active_ff || (step && final_beat));

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         beat_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            active_ff <= 1'b1;
            beat_ff   <= '0;
         end else if (step) begin
            if (final_beat) active_ff <= 1'b0;
            beat_ff <= beat_ff + BEAT_BITS'(1);
         end
         if (step)          valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cmd_ff <= q_head;
      if (step) begin
         nconfig_ff <= cmd_ff.nconfig;
         status_ff  <= cmd_ff.status;
         last_ff    <= final_beat;
         if (cmd_ff.burst) begin
            dclk_ff  <= !beat_ff[0];
            data0_ff <= cmd_ff.data_byte[beat_ff[BEAT_BITS-1:1]];
         end else begin
            dclk_ff  <= 1'b0;
            data0_ff <= cmd_ff.data0;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_nconfig_out = nconfig_ff;
   assign rsp_dclk_out    = dclk_ff;
   assign rsp_data0_out   = data0_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== sv/fpga_passive_serial_loader_unit.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  mode, data_byte, nstatus_pin, conf_done_pin
// rsp       out        rsp_valid/rsp_ready  nconfig_out, dclk_out, data0_out, status, last
// csr       in         csr_we               csr_index, csr_wdata
//
// A data byte in the loading phase gives 16 results, one per cycle from the output
// register while rsp_ready is high; every other item gives one. The front takes one
// item per cycle while the 4-entry command queue has room; the back end paces bytes.
// Synchronous reset returns the front to nCONFIG high and the registers to defaults.
// A stalled rsp_ready holds the output register; the queue then fills and drops req_ready.
module fpga_passive_serial_loader_unit
   import fpsl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_mode,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_nstatus_pin,
   input  logic                    req_conf_done_pin,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_nconfig_out,
   output logic                    rsp_dclk_out,
   output logic                    rsp_data0_out,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   logic    q_full, q_push, q_pop, q_empty;
   cmd_type q_cmd, q_head;

   fpsl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_data_byte     (req_data_byte),
      .req_nstatus_pin   (req_nstatus_pin),
      .req_conf_done_pin (req_conf_done_pin),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_cmd             (q_cmd)
   );

   fpsl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (q_head)
   );

   fpsl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_nconfig_out (rsp_nconfig_out),
      .rsp_dclk_out    (rsp_dclk_out),
      .rsp_data0_out   (rsp_data0_out),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
   import fpsl_pkg::*;
();

   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 190;

   typedef struct {
      logic       nconfig;
      logic       dclk;
      logic       data0;
      logic [2:0] status;
      logic       last;
   } pin_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [1:0]              req_mode;
   logic [7:0]              req_data_byte;
   logic                    req_nstatus_pin;
   logic                    req_conf_done_pin;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_nconfig_out;
   logic                    rsp_dclk_out;
   logic                    rsp_data0_out;
   logic [2:0]              rsp_status;
   logic                    rsp_last;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   fpga_passive_serial_loader_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_data_byte     (req_data_byte),
      .req_nstatus_pin   (req_nstatus_pin),
      .req_conf_done_pin (req_conf_done_pin),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_nconfig_out   (rsp_nconfig_out),
      .rsp_dclk_out      (rsp_dclk_out),
      .rsp_data0_out     (rsp_data0_out),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // loader state as predicted from the accepted items
   phase_type            load_phase;
   logic [COUNT_BITS-1:0] tick_count;
   logic [2:0]           load_status;
   logic                 pin_nconfig;
   logic                 pin_dclk;
   logic                 pin_data0;
   logic [CFG_BITS-1:0]  pulse_ticks;
   logic [CFG_BITS-1:0]  init_timeout;
   logic [CFG_BITS-1:0]  done_timeout;
   pin_result_type       pin_expect_q[$];

   bit quiet;
   int errors;
   int items_sent;
   int results_seen;
   int sessions;
   int settings_used;
   int stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void reset_loader_model();
      pulse_ticks  = PULSE_TICKS_RESET;
      init_timeout = INIT_TIMEOUT_RESET;
      done_timeout = DONE_TIMEOUT_RESET;
      load_phase   = PH_IDLE;
      tick_count   = '0;
      load_status  = ST_IDLE;
      pin_nconfig  = 1'b1;
      pin_dclk     = 1'b0;
      pin_data0    = 1'b0;
   endfunction

   function automatic void post_pins(input logic last_flag);
      pin_result_type r;
      r.nconfig = pin_nconfig;
      r.dclk    = pin_dclk;
      r.data0   = pin_data0;
      r.status  = load_status;
      r.last    = last_flag;
      pin_expect_q.push_back(r);
   endfunction

   function automatic bit count_tick(input logic [CFG_BITS-1:0] limit);
      if (tick_count != '1) tick_count = tick_count + 1'b1;
      return tick_count >= limit;
   endfunction

   function automatic void close_load(input logic [2:0] code);
      load_status = code;
      load_phase  = PH_FINISHED;
      tick_count  = '0;
   endfunction

   function automatic void predict_pins(input logic [1:0] mode, input logic [7:0] bits,
                                        input logic nstatus, input logic conf_done);
      int b;
      bit shifted;
      shifted = 1'b0;
      case (mode)
         MODE_START: begin
            pin_nconfig = 1'b0;
            pin_dclk    = 1'b0;
            pin_data0   = 1'b0;
            load_phase  = PH_PULSE;
            tick_count  = '0;
            load_status = ST_BUSY;
         end
         MODE_DATA: begin
            if (load_phase == PH_LOAD) begin
               for (b = 0; b < 8; b++) begin
                  pin_data0 = bits[b];
                  pin_dclk  = 1'b1;
                  post_pins(1'b0);
                  pin_dclk  = 1'b0;
                  post_pins(b == 7);
               end
               shifted = 1'b1;
            end
         end
         MODE_END: begin
            if (load_phase == PH_LOAD) begin
               if (!nstatus) begin
                  close_load(ST_PROG_ERR);
               end else begin
                  load_phase = PH_DWAIT;
                  tick_count = '0;
               end
            end
         end
         default: begin
            if (load_phase == PH_PULSE) begin
               if (count_tick(pulse_ticks)) begin
                  if (nstatus) begin
                     close_load(ST_ABSENT);
                  end else begin
                     pin_nconfig = 1'b1;
                     load_phase  = PH_INIT;
                     tick_count  = '0;
                  end
               end
            end else if (load_phase == PH_INIT) begin
               if (nstatus) begin
                  load_phase = PH_LOAD;
                  tick_count = '0;
               end else if (count_tick(init_timeout)) begin
                  close_load(ST_INIT_TO);
               end
            end else if (load_phase == PH_DWAIT) begin
               if (conf_done) close_load(ST_OK);
               else if (count_tick(done_timeout)) close_load(ST_DONE_TO);
            end
         end
      endcase
      if (!shifted) post_pins(1'b1);
   endfunction

   task automatic send_item(input logic [1:0] mode, input logic [7:0] bits,
                            input logic nstatus, input logic conf_done);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_data_byte     <= bits;
      req_nstatus_pin   <= nstatus;
      req_conf_done_pin <= conf_done;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
      predict_pins(mode, bits, nstatus, conf_done);
   endtask

   // drop valid and let the loader drain before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pin_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_PULSE_TICKS:  pulse_ticks  = val;
         CSR_INIT_TIMEOUT: init_timeout = val;
         CSR_DONE_TIMEOUT: done_timeout = val;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [CFG_BITS-1:0] pulse, input logic [CFG_BITS-1:0] init,
                             input logic [CFG_BITS-1:0] done);
      wait_idle();
      write_reg(CSR_PULSE_TICKS, pulse);
      write_reg(CSR_INIT_TIMEOUT, init);
      write_reg(CSR_DONE_TIMEOUT, done);
      settings_used++;
   endtask

   task automatic check_result();
      pin_result_type exp;
      results_seen++;
      if (pin_expect_q.size() == 0) begin
         $error("unexpected result item: status %0d last %0d", rsp_status, rsp_last);
         errors++;
      end else begin
         exp = pin_expect_q.pop_front();
         if (rsp_nconfig_out !== exp.nconfig) begin
            $error("nconfig_out expected %0d got %0d", exp.nconfig, rsp_nconfig_out);
            errors++;
         end
         if (rsp_dclk_out !== exp.dclk) begin
            $error("dclk_out expected %0d got %0d", exp.dclk, rsp_dclk_out);
            errors++;
         end
         if (rsp_data0_out !== exp.data0) begin
            $error("data0_out expected %0d got %0d", exp.data0, rsp_data0_out);
            errors++;
         end
         if (rsp_status !== exp.status) begin
            $error("status expected %0d got %0d", exp.status, rsp_status);
            errors++;
         end
         if (rsp_last !== exp.last) begin
            $error("last expected %0d got %0d", exp.last, rsp_last);
            errors++;
         end
      end
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         check_result();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic test_ignored_at_idle();
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b1);
      send_item(MODE_DATA, 8'hFF, 1'b0, 1'b0);
      send_item(MODE_END, 8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_abort_restart();
      send_item(MODE_START, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
      send_item(MODE_START, 8'hFF, 1'b1, 1'b1);
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b0);
   endtask

   task automatic test_absent_device();
      send_item(MODE_START, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b0);
      send_item(MODE_DATA, 8'h3C, 1'b1, 1'b0);
      send_item(MODE_END, 8'h00, 1'b1, 1'b0);
   endtask

   task automatic test_init_timeout();
      send_item(MODE_START, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b1);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_program_error();
      send_item(MODE_START, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b0);
      send_item(MODE_DATA, 8'h00, 1'b1, 1'b0);
      send_item(MODE_DATA, 8'hFF, 1'b1, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
      send_item(MODE_END, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_done_paths();
      send_item(MODE_START, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b0);
      send_item(MODE_DATA, 8'hA5, 1'b1, 1'b0);
      send_item(MODE_END, 8'h00, 1'b1, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b0);
      send_item(MODE_START, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b0);
      send_item(MODE_END, 8'h00, 1'b1, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b1);
   endtask

   task automatic test_register_extremes();
      set_timing('1, '1, '1);
      send_item(MODE_START, 8'h00, 1'b0, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b1, 1'b0);
      send_item(MODE_TICK, 8'h00, 1'b0, 1'b0);
      send_item(MODE_START, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 9) == 0)
         send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic run_session();
      int guard;
      int nbytes;
      send_item(MODE_START, 8'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      guard = 0;
      while (load_phase == PH_PULSE && guard < 12) begin
         maybe_noise();
         send_item(MODE_TICK, 8'($urandom), $urandom_range(0, 7) == 0,
                   1'($urandom_range(0, 1)));
         guard++;
      end
      guard = 0;
      while (load_phase == PH_INIT && guard < 12) begin
         maybe_noise();
         send_item(MODE_TICK, 8'($urandom), $urandom_range(0, 2) == 0,
                   1'($urandom_range(0, 1)));
         guard++;
      end
      if (load_phase == PH_LOAD) begin
         nbytes = $urandom_range(1, 4);
         repeat (nbytes) begin
            maybe_noise();
            send_item(MODE_DATA, 8'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
         send_item(MODE_END, 8'($urandom), $urandom_range(0, 7) != 0,
                   1'($urandom_range(0, 1)));
      end
      guard = 0;
      while (load_phase == PH_DWAIT && guard < 12) begin
         maybe_noise();
         send_item(MODE_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) == 0);
         guard++;
      end
      sessions++;
   endtask

   task automatic test_random_sessions();
      int first;
      int k;
      first = items_sent;
      for (k = 0; k < 4; k++) begin
         case (k)
            0: set_timing(20'd3, 20'd4, 20'd4);
            1: set_timing(20'd1, 20'd1, 20'd1);
            2: set_timing(20'd2, '1, '1);
            default: set_timing(CFG_BITS'($urandom_range(1, 6)),
                                 CFG_BITS'($urandom_range(1, 6)),
                                 CFG_BITS'($urandom_range(1, 6)));
         endcase
         while (items_sent - first < (k + 1) * (RANDOM_ITEMS / 4)) begin
            quiet = ($urandom_range(0, 3) == 0);
            run_session();
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      errors        = 0;
      items_sent    = 0;
      results_seen  = 0;
      sessions      = 0;
      settings_used = 1;
      quiet         = 1'b0;
      reset_loader_model();
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_mode          <= MODE_TICK;
      req_data_byte     <= '0;
      req_nstatus_pin   <= 1'b0;
      req_conf_done_pin <= 1'b0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_PULSE_TICKS;
      csr_wdata         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_at_idle();
      test_abort_restart();
      set_timing('0, 20'd2, 20'd2);
      test_absent_device();
      test_init_timeout();
      test_program_error();
      test_done_paths();
      test_register_extremes();
      test_random_sessions();
      wait_idle();
      repeat (40) @(posedge clock);

      $display("Sent %0d items (%0d random sessions) under %0d register settings",
               items_sent, sessions, settings_used);
      $display("Checked %0d result items, %0d mismatches", results_seen, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
